[hw/rtl/first_fit_sector_allocator_defines.svh]
// assertion macros for the first-fit sector allocator
// no dependencies; included by files that carry concurrent checks
`ifndef FIRST_FIT_SECTOR_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SECTOR_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FFSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define FFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/ffsa_pkg.sv]
// shared types, constants and mask helpers for the first-fit sector allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

   localparam int MAP_SECTORS = 4096;
   localparam int WORD_BITS   = 64;
   localparam int NUM_WORDS   = MAP_SECTORS / WORD_BITS;
   localparam int WADDR_W     = $clog2(NUM_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int SEC_W       = $clog2(MAP_SECTORS);
   localparam int LEN_W       = SEC_W + 1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZERO = 2'd1;
   localparam logic [1:0] STAT_CAP  = 2'd2;

   typedef enum logic [1:0] {
      CMD_RESERVE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_MARK    = 2'd2,
      CMD_INIT    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_COMMIT,
      S_SPAN,
      S_RESP
   } state_type;

   // word value after init: bits below the prefix are used
   function automatic logic [WORD_BITS-1:0] fill_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [7:0] fill);
      logic [WADDR_W-1:0] fw;
      logic [WORD_BITS-1:0] m;
      fw = WADDR_W'(fill >> BIT_W);
      if (w < fw) begin
         m = '1;
      end else if (w == fw) begin
         m = ~({WORD_BITS{1'b1}} << fill[BIT_W-1:0]);
      end else begin
         m = '0;
      end
      return m;
   endfunction

   // bits of word w inside the sector span [b, e)
   function automatic logic [WORD_BITS-1:0] span_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [SEC_W-1:0] b,
                                                      input logic [LEN_W-1:0] e);
      logic [SEC_W-1:0] el;
      logic [BIT_W-1:0] lo;
      logic [BIT_W-1:0] hi;
      el = SEC_W'(e - LEN_W'(1));
      lo = (w == b[SEC_W-1:BIT_W]) ? b[BIT_W-1:0] : '0;
      hi = (w == el[SEC_W-1:BIT_W]) ? el[BIT_W-1:0] : '1;
      return ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
   endfunction

endpackage

`default_nettype wire

[hw/rtl/ffsa_word_ram.sv]
// bitmap storage: one used bit per sector, packed into 64-bit words
// one write port, one read port with registered read data; uses ffsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module ffsa_word_ram
   import ffsa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [WADDR_W-1:0]   rd_addr,
   output logic      [WORD_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [WADDR_W-1:0]   wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/first_fit_sector_allocator.sv]
// release and mark read-modify-write each bitmap word the span touches; reserve first
// scans the words from the prefix up to the first fit (at most 64) and then writes its span,
// or writes it at once when the map does not reach past the prefix; init clears the bitmap.
// one command is in work at a time; the scan reads one 64-bit word per cycle.
// after reset the bitmap is cleared by a pass over all 64 words, req_tready stays low meanwhile.
// reset is synchronous, active high; the prefix register resets to 2, the map length to 0.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_sector_allocator_defines.svh"

module first_fit_sector_allocator
   import ffsa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // command[1:0], sector[13:2], count[26:14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // start_sector[11:0], status[13:12], map_length[26:14]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data    // reserved_prefix
);

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [7:0]           prefix_ff;
   logic [LEN_W-1:0]     map_len_ff, map_len_in;
   logic [LEN_W-1:0]     run_ff, run_in;
   logic [LEN_W-1:0]     start_ff, start_in;
   logic [1:0]           status_ff, status_in;
   logic [WADDR_W-1:0]   issue_ff, issue_in;
   logic                 issue_on_ff, issue_on_in;
   logic                 dat_vld_ff;
   logic [WADDR_W-1:0]   dat_word_ff;
   logic [SEC_W-1:0]     span_b_ff, span_b_in;
   logic [LEN_W-1:0]     span_e_ff, span_e_in;
   logic                 span_set_ff, span_set_in;
   logic [7:0]           fill_ff, fill_in;
   logic [WADDR_W-1:0]   clr_ff, clr_in;
   logic                 clr_resp_ff, clr_resp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;

   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   ffsa_word_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // free-run search over the word in rd_data
   logic [WORD_BITS-1:0] lv;
   logic [BIT_W-1:0]     li [WORD_BITS];
   logic [LEN_W-1:0]     rj [WORD_BITS];
   logic [WORD_BITS-1:0] hit;
   logic                 hit_any;
   logic [BIT_W-1:0]     hit_idx;
   logic [LEN_W-1:0]     hit_start;
   logic [SEC_W-1:0]     ml1;
   logic [WADDR_W-1:0]   scan_last;
   logic [LEN_W-1:0]     run_tail;

   assign ml1       = SEC_W'(map_len_ff - LEN_W'(1));
   assign scan_last = ml1[SEC_W-1:BIT_W];
   assign run_tail  = rj[ml1[BIT_W-1:0]];

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         lv[j] = rd_data[j] | ({dat_word_ff, BIT_W'(j)} < {4'd0, prefix_ff});
         li[j] = BIT_W'(j);
      end
      // prefix pass: index of the latest used bit at or below each position
      for (int d = 1; d < WORD_BITS; d = d * 2) begin
         for (int j = WORD_BITS - 1; j >= d; j--) begin
            if (!lv[j]) begin
               lv[j] = lv[j-d];
               li[j] = li[j-d];
            end
         end
      end
      hit_any = 1'b0;
      hit_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         rj[j]  = lv[j] ? LEN_W'(BIT_W'(j) - li[j]) : run_ff + LEN_W'(j) + LEN_W'(1);
         hit[j] = (rj[j] >= cnt_ff) && ({1'b0, dat_word_ff, BIT_W'(j)} < map_len_ff);
      end
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_any = 1'b1;
            hit_idx = BIT_W'(j);
         end
      end
      hit_start = {1'b0, dat_word_ff, hit_idx} + LEN_W'(1) - cnt_ff;
   end

   logic [LEN_W-1:0]   init_len;
   logic [LEN_W:0]     req_end;
   logic [LEN_W:0]     rsv_end;
   logic [SEC_W-1:0]   rel_b;
   logic [LEN_W-1:0]   rel_e;
   logic [WADDR_W-1:0] span_last;
   logic [SEC_W-1:0]   span_el;

   assign init_len  = (cnt_ff > LEN_W'(prefix_ff)) ? cnt_ff : LEN_W'(prefix_ff);
   assign req_end   = {2'b0, sec_ff} + {1'b0, cnt_ff};
   assign rsv_end   = {1'b0, start_ff} + {1'b0, cnt_ff};
   assign rel_b     = (sec_ff > SEC_W'(prefix_ff)) ? sec_ff : SEC_W'(prefix_ff);
   assign rel_e     = (req_end < {1'b0, map_len_ff}) ? LEN_W'(req_end) : map_len_ff;
   assign span_el   = SEC_W'(span_e_ff - LEN_W'(1));
   assign span_last = span_el[SEC_W-1:BIT_W];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sec_in       = sec_ff;
      cnt_in       = cnt_ff;
      map_len_in   = map_len_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      status_in    = status_ff;
      issue_in     = issue_ff;
      issue_on_in  = issue_on_ff;
      span_b_in    = span_b_ff;
      span_e_in    = span_e_ff;
      span_set_in  = span_set_ff;
      fill_in      = fill_ff;
      clr_in       = clr_ff;
      clr_resp_in  = clr_resp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff;
      wr_en        = 1'b0;
      wr_addr      = dat_word_ff;
      wr_data      = rd_data;

      // word reads for scan and span passes
      if ((state_ff == S_SCAN || state_ff == S_SPAN) && issue_on_ff) begin
         rd_en = 1'b1;
         if (issue_ff == ((state_ff == S_SCAN) ? scan_last : span_last)) begin
            issue_on_in = 1'b0;
         end else begin
            issue_in = issue_ff + WADDR_W'(1);
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = fill_mask(clr_ff, fill_ff);
            clr_in  = clr_ff + WADDR_W'(1);
            if (clr_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tdata[1:0]);
               sec_in    = req_tdata[13:2];
               cnt_in    = req_tdata[26:14];
               status_in = STAT_OK;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            if (cmd_ff == CMD_INIT) begin
               if (init_len > LEN_W'(MAP_SECTORS)) begin
                  status_in = STAT_CAP;
               end else begin
                  map_len_in  = init_len;
                  fill_in     = prefix_ff;
                  clr_in      = '0;
                  clr_resp_in = 1'b1;
                  state_in    = S_CLEAR;
               end
            end else if (cnt_ff == '0) begin
               status_in = STAT_ZERO;
            end else if (cmd_ff == CMD_RESERVE) begin
               if (map_len_ff > LEN_W'(prefix_ff)) begin
                  run_in      = '0;
                  issue_in    = WADDR_W'(prefix_ff >> BIT_W);
                  issue_on_in = 1'b1;
                  state_in    = S_SCAN;
               end else begin
                  start_in = LEN_W'(prefix_ff);
                  state_in = S_COMMIT;
               end
            end else if (req_end > (LEN_W + 1)'(MAP_SECTORS)) begin
               status_in = STAT_CAP;
            end else if (cmd_ff == CMD_RELEASE) begin
               if ({1'b0, rel_b} < rel_e) begin
                  span_b_in   = rel_b;
                  span_e_in   = rel_e;
                  span_set_in = 1'b0;
                  issue_in    = rel_b[SEC_W-1:BIT_W];
                  issue_on_in = 1'b1;
                  state_in    = S_SPAN;
               end
            end else begin
               span_b_in   = sec_ff;
               span_e_in   = LEN_W'(req_end);
               span_set_in = 1'b1;
               issue_in    = sec_ff[SEC_W-1:BIT_W];
               issue_on_in = 1'b1;
               if (LEN_W'(req_end) > map_len_ff) begin
                  map_len_in = LEN_W'(req_end);
               end
               state_in = S_SPAN;
            end
         end
         S_SCAN: begin
            if (dat_vld_ff) begin
               if (hit_any) begin
                  start_in    = hit_start;
                  issue_on_in = 1'b0;
                  state_in    = S_COMMIT;
               end else if (dat_word_ff == scan_last) begin
                  start_in = map_len_ff - run_tail;
                  state_in = S_COMMIT;
               end else begin
                  run_in = rj[WORD_BITS-1];
               end
            end
         end
         S_COMMIT: begin
            if (rsv_end > (LEN_W + 1)'(MAP_SECTORS)) begin
               status_in = STAT_CAP;
               state_in  = S_RESP;
            end else begin
               span_b_in   = SEC_W'(start_ff);
               span_e_in   = LEN_W'(rsv_end);
               span_set_in = 1'b1;
               issue_in    = start_ff[SEC_W-1:BIT_W];
               issue_on_in = 1'b1;
               if (LEN_W'(rsv_end) > map_len_ff) begin
                  map_len_in = LEN_W'(rsv_end);
               end
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            if (dat_vld_ff) begin
               // read-modify-write of the word that just came back
               wr_en   = 1'b1;
               wr_data = span_set_ff
                  ? (rd_data | span_mask(dat_word_ff, span_b_ff, span_e_ff))
                  : (rd_data & ~span_mask(dat_word_ff, span_b_ff, span_e_ff));
               if (dat_word_ff == span_last) begin
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, map_len_ff, status_ff,
                               (cmd_ff == CMD_RESERVE && status_ff == STAT_OK)
                                  ? SEC_W'(start_ff) : SEC_W'(0)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         map_len_ff   <= '0;
         prefix_ff    <= 8'd2;
         issue_on_ff  <= 1'b0;
         dat_vld_ff   <= 1'b0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_len_ff   <= map_len_in;
         issue_on_ff  <= issue_on_in;
         dat_vld_ff   <= rd_en;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            prefix_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sec_ff      <= sec_in;
      cnt_ff      <= cnt_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      status_ff   <= status_in;
      issue_ff    <= issue_in;
      dat_word_ff <= issue_ff;
      span_b_ff   <= span_b_in;
      span_e_ff   <= span_e_in;
      span_set_ff <= span_set_in;
      rsp_data_ff <= rsp_data_in;
   end

   `FFSA_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, map_len_ff <= LEN_W'(MAP_SECTORS))
   `FFSA_ASSERT_NEXT(a_one_cmd, clock, reset, req_tvalid && req_tready, !req_tready)
   `FFSA_ASSERT_SAME(a_span_write, clock, reset, wr_en && state_ff == S_SPAN,
      dat_word_ff >= span_b_ff[SEC_W-1:BIT_W] && dat_word_ff <= span_last)

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench for the first-fit sector allocator
// depends on ffsa_pkg and first_fit_sector_allocator; predicts every response in a scoreboard
`timescale 1ns / 1ps

module testbench;
   import ffsa_pkg::*;

   class alloc_scoreboard;
      bit          used[MAP_SECTORS];
      int unsigned map_len;
      int unsigned prefix;
      logic [31:0] pending[$];
      int          errors;

      function new();
         foreach (used[i]) used[i] = 0;
         map_len = 0;
         prefix = 2;
         errors = 0;
      endfunction

      function void set_prefix(logic [7:0] v);
         prefix = v;
      endfunction

      function void set_span(int unsigned b, int unsigned e);
         for (int unsigned i = b; i < e && i < MAP_SECTORS; i++) used[i] = 1;
         if (e > map_len) map_len = e;
      endfunction

      // apply one accepted command and queue the response it must produce
      function void note_request(logic [31:0] d);
         cmd_type     cmd;
         int unsigned sec, cnt, st, start, run, e, b, len;
         logic [1:0]  status;
         logic [31:0] rsp;
         cmd = cmd_type'(d[1:0]);
         sec = d[13:2];
         cnt = d[26:14];
         status = STAT_OK;
         start = 0;
         if (cmd == CMD_INIT) begin
            len = cnt > prefix ? cnt : prefix;
            if (len > MAP_SECTORS) status = STAT_CAP;
            else begin
               foreach (used[i]) used[i] = 0;
               map_len = len;
               for (int unsigned i = 0; i < prefix; i++) used[i] = 1;
            end
         end else if (cnt == 0) status = STAT_ZERO;
         else if (cmd == CMD_RESERVE) begin
            run = 0;
            st = 0;
            for (int unsigned i = prefix; i < map_len && i < MAP_SECTORS; i++) begin
               run = used[i] ? 0 : run + 1;
               if (run >= cnt) begin
                  start = i + 1 - cnt;
                  st = 1;
                  break;
               end
            end
            if (st == 0) begin
               // fall back to the trailing free run and grow the map
               start = map_len > prefix ? map_len : prefix;
               start -= (run < start - prefix) ? run : (start - prefix);
            end
            if (start + cnt > MAP_SECTORS) begin
               status = STAT_CAP;
               start = 0;
            end else set_span(start, start + cnt);
         end else begin
            e = sec + cnt;
            if (e > MAP_SECTORS) status = STAT_CAP;
            else if (cmd == CMD_RELEASE) begin
               b = sec > prefix ? sec : prefix;
               for (int unsigned i = b; i < e && i < map_len; i++) used[i] = 0;
            end else set_span(sec, e);
         end
         rsp = '0;
         rsp[11:0] = start[11:0];
         rsp[13:12] = status;
         rsp[26:14] = map_len[12:0];
         pending.push_back(rsp);
      endfunction

      function void check_response(logic [31:0] act);
         logic [31:0] exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, act);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (act[11:0] !== exp[11:0]) begin
            $display("%0t: start_sector expected %0d actual %0d", $realtime, exp[11:0], act[11:0]);
            errors++;
         end
         if (act[13:12] !== exp[13:12]) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp[13:12], act[13:12]);
            errors++;
         end
         if (act[26:14] !== exp[26:14]) begin
            $display("%0t: map_length expected %0d actual %0d", $realtime,
                     exp[26:14], act[26:14]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // command[1:0], sector[13:2], count[26:14]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;       // start_sector[11:0], status[13:12], map_length[26:14]
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int send_idle = 35;
   int recv_idle = 78;
   alloc_scoreboard board = new();

   first_fit_sector_allocator uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // valid stays up after a transfer until the next idle cycle or drain drops it
   task automatic send_command(cmd_type cmd, int unsigned sec, int unsigned cnt);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, cnt[12:0], sec[11:0], cmd};
      do @(posedge clock); while (!req_tready);
      board.note_request(req_tdata);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_prefix(logic [7:0] v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      board.set_prefix(v);
      csr_valid <= 0;
   endtask

   // mostly small spans so runs and holes form, now and then the extremes
   task automatic random_command();
      int unsigned cmd, sec, cnt, r;
      r = $urandom_range(99);
      cmd = r < 45 ? CMD_RESERVE : r < 75 ? CMD_RELEASE : r < 95 ? CMD_MARK : CMD_INIT;
      r = $urandom_range(99);
      cnt = r < 70 ? $urandom_range(1, 40) : r < 85 ? $urandom_range(0, 400)
            : r < 95 ? $urandom_range(0, 8191) : 4096;
      if (cmd == CMD_INIT && r < 85) cnt = $urandom_range(0, 300);
      sec = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(400);
      send_command(cmd_type'(cmd), sec, cnt);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed
      send_command(CMD_RESERVE, 0, 5);
      send_command(CMD_RESERVE, 0, 0);
      send_command(CMD_RELEASE, 4095, 8191);
      send_command(CMD_MARK, 4095, 1);
      send_command(CMD_RELEASE, 0, 4096);
      send_command(CMD_INIT, 0, 0);
      send_command(CMD_INIT, 0, 8191);
      send_command(CMD_INIT, 4095, 100);
      send_command(CMD_RESERVE, 0, 10);
      send_command(CMD_RELEASE, 3, 4);
      send_command(CMD_RESERVE, 0, 2);
      send_command(CMD_RESERVE, 0, 200);
      send_command(CMD_RESERVE, 0, 4096);
      send_command(CMD_MARK, 0, 4096);
      send_command(CMD_RELEASE, 500, 3000);
      send_command(CMD_RESERVE, 0, 4000);
      send_command(CMD_MARK, 2048, 0);
      write_prefix(8'd255);
      send_command(CMD_INIT, 0, 10);
      send_command(CMD_RESERVE, 0, 3);
      write_prefix(8'd0);
      send_command(CMD_RESERVE, 0, 1);
      send_command(CMD_RELEASE, 0, 4);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle = 78;
            recv_idle = 35;
         end
         if (ph == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_prefix(ph == 5 ? 8'd1 : ph == 3 ? 8'd255 : 8'($urandom_range(255)));
         send_command(CMD_INIT, 0, $urandom_range(0, 300));
         for (int n = 0; n < 215; n++) begin
            random_command();
            if (n == 100) drain();
         end
      end
      drain();
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
